// ===== hdl/conv5x5_image_filter_macros.svh =====
// ----------------------------------------------------------------------------
// conv5x5_image_filter assertion macros
// Shared concurrent assertion forms for the 5x5 filter RTL.
// ----------------------------------------------------------------------------
`ifndef CONV5X5_IMAGE_FILTER_MACROS_SVH
`define CONV5X5_IMAGE_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define C5IF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define C5IF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/c5if_pkg.sv =====
// ----------------------------------------------------------------------------
// c5if_pkg
// Constants, codes and kernel table of the 5x5 image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c5if_pkg;

    // pixel and image geometry
    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 5;
    localparam int DIM_W      = 11;                       // size register width
    localparam int COL_W      = $clog2(MAX_WIDTH);        // column index
    localparam int OROW_W     = $clog2(MAX_HEIGHT);       // output row index
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 3);   // input row runs past the frame

    // kernel geometry
    localparam int KSIZE     = 5;
    localparam int KHALF     = KSIZE / 2;
    localparam int KTAPS     = KSIZE * KSIZE;
    localparam int LINE_ROWS = KSIZE - 1;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd16;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd16;

    // filter codes
    localparam int FSEL_W      = 2;
    localparam int NUM_FILTERS = 4;
    localparam logic [FSEL_W-1:0] FILTER_BLUR    = 2'd0;
    localparam logic [FSEL_W-1:0] FILTER_SHARPEN = 2'd1;
    localparam logic [FSEL_W-1:0] FILTER_RELIEF  = 2'd2;
    localparam logic [FSEL_W-1:0] FILTER_EDGE    = 2'd3;

    // arithmetic widths
    localparam int COEF_W    = 5;
    localparam int PROD_W    = PIX_W + COEF_W + 1;
    localparam int ROWSUM_W  = 14;
    localparam int SUM_W     = 15;

    // blur divides by 37: x / 37 == (x * 14170) >> 19 for 0 <= x < 2^18
    localparam int RECIP_W    = 14;
    localparam int DIV_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] BLUR_RECIP = 14'd14170;
    localparam int BLUR_SHIFT = 19;
    // edge divides by 4
    localparam int EDGE_SHIFT = 2;
    localparam logic [SUM_W-1:0] PIX_MAX = 15'd255;

    // result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // row-major 5x5 coefficients, one row per filter code
    localparam logic signed [COEF_W-1:0] KERNEL_TABLE [NUM_FILTERS][KTAPS] = '{
        '{ 5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,
           5'sd0,  5'sd2,  5'sd4,  5'sd2,  5'sd0,
           5'sd1,  5'sd4,  5'sd9,  5'sd4,  5'sd1,
           5'sd0,  5'sd2,  5'sd4,  5'sd2,  5'sd0,
           5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0 },
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,
           5'sd0,  5'sd0, -5'sd1,  5'sd0,  5'sd0,
           5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0,
           5'sd0,  5'sd0, -5'sd1,  5'sd0,  5'sd0,
           5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0 },
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,
           5'sd0, -5'sd2, -5'sd1,  5'sd0,  5'sd0,
           5'sd0, -5'sd1,  5'sd1,  5'sd1,  5'sd0,
           5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd0,
           5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0 },
        '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,
           5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,
           5'sd0,  5'sd2, -5'sd12, 5'sd2,  5'sd0,
           5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,
           5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0 }
    };

endpackage

`default_nettype wire

// ===== hdl/conv5x5_image_filter.sv =====
// ----------------------------------------------------------------------------
// conv5x5_image_filter
// 5x5 convolution of an 8-bit grey raster stream with a zero border.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / pixel_in / is_flush) takes pixels in
//   raster order, one item per clock while in_stall is low. After the W*H
//   pixels of a frame, send 2*W + 2 flush items to drain the last two rows.
//   Output channel (out_valid / out_stall / pixel_out / frame_end) gives one
//   filtered pixel per centre pixel; frame_end marks the last one, and the
//   next item then opens a new frame. Configuration writes (cfg_valid /
//   cfg_ready, always ready) select the kernel and the image size; a size
//   write restarts the frame. Sizes outside 5..1024 are saturated.
//   An item's result passes the input, window, row-sum and sum registers and
//   the result queue before output. Throughput: one item per cycle while
//   in_stall is low, set by the single line-store read of one 4-row column per item.
//   Reset clears counters, queue and config (blur, 16x16). The line store
//   needs no clearing: rows outside the frame are masked.
//   When the receiver stalls, the head result holds and up to eight results
//   queue up; the input stalls once eight results are owed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv5x5_image_filter_macros.svh"

module conv5x5_image_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [c5if_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [c5if_pkg::DIM_W-1:0]     cfg_data,
    // pixel input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [c5if_pkg::PIX_W-1:0]     pixel_in,
    input  logic                           is_flush,
    // filtered output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [c5if_pkg::PIX_W-1:0]     pixel_out,
    output logic                           frame_end
);

    import c5if_pkg::*;

    typedef struct packed {
        logic             emit;
        logic             frame_end;
        logic [KSIZE-1:0] row_ok;
        logic [KSIZE-1:0] col_ok;
    } stage_meta_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic              cfg_fire;
    logic              size_write;
    logic [FSEL_W-1:0] filter_sel_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign size_write = cfg_fire
                        && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_sel_reg <= FILTER_BLUR;
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_FILTER_SELECT: filter_sel_reg <= cfg_data[FSEL_W-1:0];
                REG_IMAGE_WIDTH:   width_reg      <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg     <= cfg_data;
                default:           ;  // drop writes beyond the register list
            endcase
        end
    end

    // saturate the sizes actually used
    always_comb
    begin
        if (width_reg < DIM_W'(MIN_DIM))
            width_eff = DIM_W'(MIN_DIM);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg < DIM_W'(MIN_DIM))
            height_eff = DIM_W'(MIN_DIM);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // ------------------------------------------------------------------
    // position counters and result credit
    // ------------------------------------------------------------------
    logic [COL_W-1:0]     in_col_reg,  in_col_next;
    logic [ROW_W-1:0]     in_row_reg,  in_row_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [OROW_W-1:0]    out_row_reg, out_row_next;
    logic [OUT_CNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic in_fire;
    logic emit;
    logic in_col_wrap;
    logic out_col_wrap;
    logic out_row_last;
    logic frame_done;
    logic pop;
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;

    assign in_stall = (pend_cnt_reg == OUT_CNT_W'(OUT_DEPTH));
    assign in_fire  = in_valid && !in_stall;

    // the item at row 2, column 2 completes the first window of a frame;
    // from there each item releases one result until the frame is done
    assign emit = (in_row_reg > ROW_W'(KHALF))
                  || (in_row_reg == ROW_W'(KHALF) && in_col_reg >= COL_W'(KHALF));

    assign in_col_wrap  = (DIM_W'(in_col_reg)  == width_eff  - DIM_W'(1));
    assign out_col_wrap = (DIM_W'(out_col_reg) == width_eff  - DIM_W'(1));
    assign out_row_last = (DIM_W'(out_row_reg) == height_eff - DIM_W'(1));
    assign frame_done   = emit && out_col_wrap && out_row_last;

    // border masks of the window around the centre (out_row, out_col)
    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            if (i < KHALF)
            begin
                row_ok[i] = DIM_W'(out_row_reg) >= DIM_W'(KHALF - i);
                col_ok[i] = DIM_W'(out_col_reg) >= DIM_W'(KHALF - i);
            end
            else
            begin
                row_ok[i] = DIM_W'(out_row_reg) + DIM_W'(i - KHALF) < height_eff;
                col_ok[i] = DIM_W'(out_col_reg) + DIM_W'(i - KHALF) < width_eff;
            end
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (size_write || (in_fire && frame_done))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (in_fire)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        if (in_fire && emit)
            pend_cnt_next = pend_cnt_next + OUT_CNT_W'(1);
        if (pop)
            pend_cnt_next = pend_cnt_next - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_cnt_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register, line store read
    // line word byte j holds the pixel of row (current row - 1 - j)
    // ------------------------------------------------------------------
    logic                       s1_valid_reg;
    logic [PIX_W-1:0]           s1_pix_reg;
    logic [COL_W-1:0]           s1_col_reg;
    stage_meta_t                s1_meta_reg;
    logic [LINE_ROWS*PIX_W-1:0] line_rd_data;
    logic [LINE_ROWS*PIX_W-1:0] line_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg            <= is_flush ? '0 : pixel_in;
            s1_col_reg            <= in_col_reg;
            s1_meta_reg.emit      <= emit;
            s1_meta_reg.frame_end <= frame_done;
            s1_meta_reg.row_ok    <= row_ok;
            s1_meta_reg.col_ok    <= col_ok;
        end
    end

    // push the column down one row: newest pixel in, oldest row out
    assign line_wr_data = {line_rd_data[(LINE_ROWS-1)*PIX_W-1:0], s1_pix_reg};

    c5if_ram #(
        .WIDTH (LINE_ROWS * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr_data),
        .rd_en   (in_fire),
        .rd_addr (in_col_reg),
        .rd_data (line_rd_data)
    );

    // ------------------------------------------------------------------
    // stage 2: 5x5 window, newest column on the right, top row first
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [KSIZE][KSIZE];
    logic [PIX_W-1:0] new_col [KSIZE];
    logic             s2_valid_reg;
    stage_meta_t      s2_meta_reg;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            if (i == KSIZE - 1)
                new_col[i] = s1_pix_reg;
            else
                new_col[i] = line_rd_data[(LINE_ROWS-1-i)*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                for (int j = 0; j < KSIZE - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][KSIZE-1] <= new_col[i];
            end
            s2_meta_reg <= s1_meta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_meta_reg.emit;
    end

    // ------------------------------------------------------------------
    // stage 3: masked row sums
    // ------------------------------------------------------------------
    logic signed [ROWSUM_W-1:0] row_sum [KSIZE];
    logic signed [ROWSUM_W-1:0] s3_row_sum_reg [KSIZE];
    logic                       s3_valid_reg;
    logic                       s3_end_reg;
    logic [FSEL_W-1:0]          s3_sel_reg;

    always_comb
    begin
        logic signed [PROD_W-1:0] term;
        for (int i = 0; i < KSIZE; i++)
        begin
            row_sum[i] = '0;
            for (int j = 0; j < KSIZE; j++)
            begin
                term = PROD_W'(KERNEL_TABLE[filter_sel_reg][i*KSIZE+j])
                       * $signed(PROD_W'({1'b0, win_reg[i][j]}));
                if (s2_meta_reg.row_ok[i] && s2_meta_reg.col_ok[j])
                    row_sum[i] = row_sum[i] + ROWSUM_W'(term);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                s3_row_sum_reg[i] <= row_sum[i];
            end
            s3_end_reg <= s2_meta_reg.frame_end;
            s3_sel_reg <= filter_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: full sum
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] total_sum;
    logic signed [SUM_W-1:0] s4_sum_reg;
    logic                    s4_valid_reg;
    logic                    s4_end_reg;
    logic [FSEL_W-1:0]       s4_sel_reg;

    always_comb
    begin
        total_sum = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            total_sum = total_sum + SUM_W'(s3_row_sum_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            s4_sum_reg <= total_sum;
            s4_end_reg <= s3_end_reg;
            s4_sel_reg <= s3_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    // ------------------------------------------------------------------
    // divide and clamp; a non-positive sum always clamps to zero, so only
    // positive sums are divided
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] div_prod;
    logic [SUM_W-1:0] quot;
    logic [PIX_W-1:0] result_pix;

    assign div_prod = DIV_W'(s4_sum_reg[SUM_W-1:0]) * DIV_W'(BLUR_RECIP);

    always_comb
    begin
        case (s4_sel_reg)
            FILTER_BLUR:    quot = SUM_W'(div_prod >> BLUR_SHIFT);
            FILTER_EDGE:    quot = s4_sum_reg[SUM_W-1:0] >> EDGE_SHIFT;
            FILTER_SHARPEN: quot = s4_sum_reg[SUM_W-1:0];
            FILTER_RELIEF:  quot = s4_sum_reg[SUM_W-1:0];
            default:        quot = s4_sum_reg[SUM_W-1:0];
        endcase

        if (s4_sum_reg <= 0)
            result_pix = '0;
        else if (quot > PIX_MAX)
            result_pix = PIX_MAX[PIX_W-1:0];
        else
            result_pix = quot[PIX_W-1:0];
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]     fifo_pix_reg [OUT_DEPTH];
    logic                 fifo_end_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic                 fifo_push;

    assign fifo_push = s4_valid_reg;
    assign out_valid = (fifo_cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign pixel_out = fifo_pix_reg[rd_ptr_reg];
    assign frame_end = fifo_end_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next   = fifo_push ? wr_ptr_reg + OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next   = pop ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push)
            fifo_cnt_next = fifo_cnt_next + OUT_CNT_W'(1);
        if (pop)
            fifo_cnt_next = fifo_cnt_next - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_pix_reg[wr_ptr_reg] <= result_pix;
            fifo_end_reg[wr_ptr_reg] <= s4_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `C5IF_ASSERT_SAME(a_queue_no_overflow, clk, rst_n, fifo_push, fifo_cnt_reg < OUT_CNT_W'(OUT_DEPTH), "result queue overflow")
    `C5IF_ASSERT_SAME(a_credit_covers_queue, clk, rst_n, 1'b1, pend_cnt_reg >= fifo_cnt_reg, "queued results exceed owed results")
    `C5IF_ASSERT_NEXT(a_frame_restart, clk, rst_n, in_fire && frame_done, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0, "counters not cleared after frame end")
    `C5IF_ASSERT_SAME(a_output_behind_input, clk, rst_n, in_fire && emit, in_row_reg > ROW_W'(out_row_reg), "output row not behind input row")

endmodule

`default_nettype wire

// ===== hdl/c5if_ram.sv =====
// ----------------------------------------------------------------------------
// c5if_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module c5if_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
